// ===== src/imupg_pkg.sv =====
// Package: shared types, codes and reset constants of the IMU pose gesture recognizer.
package imupg_pkg;

    localparam int MOTION_W   = 17;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    typedef enum logic [1:0] {
        PH_WAIT_POSE    = 2'd0,
        PH_ARMED        = 2'd1,
        PH_WAIT_RELEASE = 2'd2,
        PH_WAIT_NEUTRAL = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        POSE_UNKNOWN = 3'd0,
        POSE_FLAT    = 3'd1,
        POSE_CCW90   = 3'd2,
        POSE_CW90    = 3'd3,
        POSE_CW180   = 3'd4
    } pose_t;

    typedef enum logic [1:0] {
        GEST_NONE  = 2'd0,
        GEST_LEFT  = 2'd1,
        GEST_RIGHT = 2'd2,
        GEST_UP    = 2'd3
    } gcode_t;

    localparam logic [REG_IDX_W-1:0] REG_TRIGGER_MOTION = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_RELEASE_MOTION = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RELEASE_TIMEOUT = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_POSE_HOLD      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ARM_MOTION     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_NEUTRAL_HOLD   = 3'd5;

    typedef struct packed {
        logic [MOTION_W-1:0] trigger_motion_level;
        logic [MOTION_W-1:0] release_motion_level;
        logic [15:0]         release_timeout_ms;
        logic [15:0]         pose_hold_ms;
        logic [MOTION_W-1:0] arm_motion_limit;
        logic [15:0]         neutral_hold_ms;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        trigger_motion_level: 17'd10000,
        release_motion_level: 17'd4000,
        release_timeout_ms:   16'd700,
        pose_hold_ms:         16'd180,
        arm_motion_limit:     17'd5000,
        neutral_hold_ms:      16'd200
    };

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
        logic [31:0]        now_ms;
    } sample_t;

    typedef struct packed {
        pose_t               pose;
        logic [MOTION_W-1:0] motion;
    } feat_t;

    function automatic logic [16:0] magnitude(input logic signed [15:0] v);
        logic [16:0] ext;
        ext = {v[15], v};
        return v[15] ? 17'(-ext) : ext;
    endfunction

    function automatic gcode_t pose_to_gesture(input pose_t p);
        gcode_t g;
        case (p)
            POSE_CCW90: g = GEST_LEFT;
            POSE_CW90:  g = GEST_RIGHT;
            POSE_CW180: g = GEST_UP;
            default:    g = GEST_NONE;
        endcase
        return g;
    endfunction

endpackage

// ===== src/imupg_if.sv =====
// Interfaces: sample input channel and result output channel.
interface imupg_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic [31:0]        now_ms;

    modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, now_ms,
                    input ready);
    modport sink (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, now_ms,
                  output ready);
endinterface

interface imupg_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] gesture_code;
    logic [1:0] phase_after;

    modport source (output valid, gesture_code, phase_after, input ready);
    modport sink (input valid, gesture_code, phase_after, output ready);
endinterface

// ===== src/imupg_cfg_regs.sv =====
// Configuration register bank behind the APB port.
module imupg_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [imupg_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [imupg_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [imupg_pkg::APB_DATA_W-1:0]   prdata,
    output logic                               pready,
    output imupg_pkg::cfg_t                    cfg
);
    import imupg_pkg::*;

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_TRIGGER_MOTION:  cfg_next.trigger_motion_level = pwdata[MOTION_W-1:0];
                REG_RELEASE_MOTION:  cfg_next.release_motion_level = pwdata[MOTION_W-1:0];
                REG_RELEASE_TIMEOUT: cfg_next.release_timeout_ms   = pwdata[15:0];
                REG_POSE_HOLD:       cfg_next.pose_hold_ms         = pwdata[15:0];
                REG_ARM_MOTION:      cfg_next.arm_motion_limit     = pwdata[MOTION_W-1:0];
                REG_NEUTRAL_HOLD:    cfg_next.neutral_hold_ms      = pwdata[15:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_TRIGGER_MOTION:  prdata = APB_DATA_W'(cfg_reg.trigger_motion_level);
            REG_RELEASE_MOTION:  prdata = APB_DATA_W'(cfg_reg.release_motion_level);
            REG_RELEASE_TIMEOUT: prdata = APB_DATA_W'(cfg_reg.release_timeout_ms);
            REG_POSE_HOLD:       prdata = APB_DATA_W'(cfg_reg.pose_hold_ms);
            REG_ARM_MOTION:      prdata = APB_DATA_W'(cfg_reg.arm_motion_limit);
            REG_NEUTRAL_HOLD:    prdata = APB_DATA_W'(cfg_reg.neutral_hold_ms);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

endmodule

// ===== src/imupg_feature.sv =====
// Pose classification and gyro motion sum for one sample.
module imupg_feature (
    input  imupg_pkg::sample_t smp,
    output imupg_pkg::feat_t   feat
);
    import imupg_pkg::*;

    logic [16:0] mag_x;
    logic [16:0] mag_y;
    logic [16:0] mag_z;

    assign mag_x = magnitude(smp.accel_x);
    assign mag_y = magnitude(smp.accel_y);
    assign mag_z = magnitude(smp.accel_z);

    // ties favor Z, then X over Y
    always_comb
    begin
        // three magnitudes of at most 32768 sum below 2^17
        feat.motion = magnitude(smp.gyro_x) + magnitude(smp.gyro_y)
                    + magnitude(smp.gyro_z);
        if (mag_z >= mag_x && mag_z >= mag_y)
            feat.pose = smp.accel_z[15] ? POSE_CW180 : POSE_FLAT;
        else if (mag_x >= mag_y)
            feat.pose = smp.accel_x[15] ? POSE_CW90 : POSE_CCW90;
        else
            feat.pose = smp.accel_y[15] ? POSE_CW90 : POSE_CCW90;
    end

endmodule

// ===== src/imupg_fsm.sv =====
// Gesture phase machine with timers and the result register.
module imupg_fsm #(
    parameter int TIME_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  imupg_pkg::feat_t      feat,
    input  logic [TIME_BITS-1:0]  now,
    input  imupg_pkg::cfg_t       cfg,
    output logic [1:0]            gesture_code,
    output logic [1:0]            phase_after
);
    import imupg_pkg::*;

    phase_t               phase_reg, phase_next;
    pose_t                locked_pose_reg, locked_pose_next;
    pose_t                prev_pose_reg, prev_pose_next;
    logic [TIME_BITS-1:0] gesture_time_reg, gesture_time_next;
    logic [TIME_BITS-1:0] pose_since_reg, pose_since_next;
    logic [TIME_BITS-1:0] neutral_since_reg, neutral_since_next;
    gcode_t               code_reg, code_next;
    phase_t               res_phase_reg;

    logic [TIME_BITS-1:0] since_gesture;
    logic [TIME_BITS-1:0] since_pose;
    logic [TIME_BITS-1:0] neutral_start;
    logic [TIME_BITS-1:0] since_neutral;
    gcode_t               fire_code;

    assign since_gesture = now - gesture_time_reg;
    assign since_pose    = now - pose_since_reg;
    // a zero stamp means the neutral hold has not started
    assign neutral_start = (neutral_since_reg == '0) ? now : neutral_since_reg;
    assign since_neutral = now - neutral_start;
    assign fire_code     = pose_to_gesture(locked_pose_reg);

    always_comb
    begin
        phase_next         = phase_reg;
        locked_pose_next   = locked_pose_reg;
        prev_pose_next     = prev_pose_reg;
        gesture_time_next  = gesture_time_reg;
        pose_since_next    = pose_since_reg;
        neutral_since_next = neutral_since_reg;
        code_next          = GEST_NONE;

        unique case (phase_reg)
            PH_WAIT_RELEASE:
            begin
                if (since_gesture > TIME_BITS'(cfg.release_timeout_ms) ||
                    feat.motion < cfg.release_motion_level)
                begin
                    phase_next         = PH_WAIT_NEUTRAL;
                    locked_pose_next   = POSE_UNKNOWN;
                    prev_pose_next     = POSE_UNKNOWN;
                    pose_since_next    = now;
                    neutral_since_next = now;
                end
            end
            PH_WAIT_NEUTRAL:
            begin
                if (feat.pose == POSE_FLAT)
                begin
                    neutral_since_next = neutral_start;
                    if (since_neutral >= TIME_BITS'(cfg.neutral_hold_ms))
                    begin
                        phase_next         = PH_WAIT_POSE;
                        locked_pose_next   = POSE_UNKNOWN;
                        prev_pose_next     = feat.pose;
                        pose_since_next    = now;
                        neutral_since_next = '0;
                    end
                end
                else
                begin
                    neutral_since_next = '0;
                end
            end
            PH_WAIT_POSE:
            begin
                if (feat.pose != prev_pose_reg)
                begin
                    locked_pose_next = POSE_UNKNOWN;
                    prev_pose_next   = feat.pose;
                    pose_since_next  = now;
                end
                else if (feat.pose == POSE_UNKNOWN || feat.pose == POSE_FLAT ||
                         feat.motion >= cfg.arm_motion_limit)
                begin
                    pose_since_next = now;
                end
                else if (since_pose >= TIME_BITS'(cfg.pose_hold_ms))
                begin
                    locked_pose_next = feat.pose;
                    phase_next       = PH_ARMED;
                end
            end
            PH_ARMED:
            begin
                if (feat.motion > cfg.trigger_motion_level)
                begin
                    code_next = fire_code;
                    if (fire_code != GEST_NONE)
                    begin
                        gesture_time_next  = now;
                        neutral_since_next = '0;
                        phase_next         = PH_WAIT_RELEASE;
                    end
                end
            end
            default: phase_next = phase_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_WAIT_POSE;
            locked_pose_reg   <= POSE_UNKNOWN;
            prev_pose_reg     <= POSE_UNKNOWN;
            gesture_time_reg  <= '0;
            pose_since_reg    <= '0;
            neutral_since_reg <= '0;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            locked_pose_reg   <= locked_pose_next;
            prev_pose_reg     <= prev_pose_next;
            gesture_time_reg  <= gesture_time_next;
            pose_since_reg    <= pose_since_next;
            neutral_since_reg <= neutral_since_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            code_reg      <= code_next;
            res_phase_reg <= phase_next;
        end
    end

    assign gesture_code = code_reg;
    assign phase_after  = res_phase_reg;

endmodule

// ===== src/imu_pose_gesture_recognizer_top.sv =====
// Top level of the IMU pose gesture recognizer.
//
//  channel     dir   handshake        word
//  sample_in   in    valid/ready      accel xyz, gyro xyz, now_ms
//  result_out  out   valid/ready      gesture_code, phase_after
//  apb         in    psel/penable     6 config registers at 4*i
//
// One word per cycle sustained while results are taken; each word passes an
// input register, then pose/motion/phase logic into the result register.
// The input register refills while a result waits, so one stalled result
// stalls input only once the input register is also full.
// rst_n clears phase, timers, pose state and both valid flags; config
// registers return to their defaults.
module imu_pose_gesture_recognizer_top #(
    parameter int TIME_BITS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    imupg_in_if.sink                         sample_in,
    imupg_out_if.source                      result_out,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [imupg_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [imupg_pkg::APB_DATA_W-1:0] pwdata,
    output logic [imupg_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready
);
    import imupg_pkg::*;

    sample_t smp_reg;
    logic    in_valid_reg, in_valid_next;
    logic    out_valid_reg, out_valid_next;
    logic    advance;
    logic    in_take;
    cfg_t    cfg;
    feat_t   feat;

    assign advance         = in_valid_reg && (!out_valid_reg || result_out.ready);
    assign sample_in.ready = !in_valid_reg || advance;
    assign in_take         = sample_in.valid && sample_in.ready;

    always_comb
    begin
        in_valid_next  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (result_out.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            smp_reg.accel_x <= sample_in.accel_x;
            smp_reg.accel_y <= sample_in.accel_y;
            smp_reg.accel_z <= sample_in.accel_z;
            smp_reg.gyro_x  <= sample_in.gyro_x;
            smp_reg.gyro_y  <= sample_in.gyro_y;
            smp_reg.gyro_z  <= sample_in.gyro_z;
            smp_reg.now_ms  <= sample_in.now_ms;
        end
    end

    assign result_out.valid = out_valid_reg;

    imupg_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    imupg_feature u_feat (
        .smp  (smp_reg),
        .feat (feat)
    );

    imupg_fsm #(
        .TIME_BITS (TIME_BITS)
    ) u_fsm (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .feat         (feat),
        .now          (smp_reg.now_ms[TIME_BITS-1:0]),
        .cfg          (cfg),
        .gesture_code (result_out.gesture_code),
        .phase_after  (result_out.phase_after)
    );

endmodule

// ===== src/imupg_checker.sv =====
// Port-level checker for the gesture recognizer, bound to the top level.
module imupg_prop_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] gesture_code,
    input logic [1:0] phase_after,
    input logic       pready
);
    import imupg_pkg::*;

    // a fired gesture always leaves the machine waiting for release
    a_gesture_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && gesture_code != GEST_NONE) |-> (phase_after == PH_WAIT_RELEASE))
        else $error("gesture reported outside release wait");

    a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result word withdrawn while stalled");

    a_out_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(gesture_code) && $stable(phase_after)))
        else $error("result word changed while stalled");

endmodule

bind imu_pose_gesture_recognizer_top imupg_prop_checker u_imupg_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (result_out.valid),
    .out_ready    (result_out.ready),
    .gesture_code (result_out.gesture_code),
    .phase_after  (result_out.phase_after),
    .pready       (pready)
);

// ===== sim/imupg_checker.sv =====
// Checker: tracks the recognizer from the observed words and compares every result word.
module imupg_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    imupg_in_if                              sample_mon,
    imupg_out_if                             result_mon,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic                             pready,
    input  logic [imupg_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [imupg_pkg::APB_DATA_W-1:0] pwdata,
    output int                               errors,
    output int                               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import imupg_pkg::*;

    typedef struct packed {
        gcode_t gesture;
        phase_t phase;
    } outcome_t;

    cfg_t        cfg;
    phase_t      phase_q;
    logic [31:0] gesture_at;
    logic [31:0] hold_from;
    logic [31:0] flat_from;
    pose_t       locked;
    pose_t       prior_pose;
    outcome_t    due_outcomes[$];
    outcome_t    want;
    sample_t     seen_word;
    gcode_t      fired;

    function automatic logic [16:0] mag17(input logic signed [15:0] v);
        int w;
        w = v;
        if (w < 0)
            w = -w;
        return w[16:0];
    endfunction

    function automatic pose_t classify_pose(input logic signed [15:0] ax,
                                            input logic signed [15:0] ay,
                                            input logic signed [15:0] az);
        logic [16:0] mx;
        logic [16:0] my;
        logic [16:0] mz;
        mx = mag17(ax);
        my = mag17(ay);
        mz = mag17(az);
        if (mz >= mx && mz >= my)
            return az[15] ? POSE_CW180 : POSE_FLAT;
        if (mx >= my)
            return ax[15] ? POSE_CW90 : POSE_CCW90;
        return ay[15] ? POSE_CW90 : POSE_CCW90;
    endfunction

    task automatic recognize(input sample_t s, output gcode_t g);
        logic [16:0] motion;
        pose_t       p;
        logic [31:0] t;
        motion = mag17(s.gyro_x) + mag17(s.gyro_y) + mag17(s.gyro_z);
        t      = s.now_ms;
        p      = classify_pose(s.accel_x, s.accel_y, s.accel_z);
        g      = GEST_NONE;
        case (phase_q)
            PH_WAIT_RELEASE:
            begin
                if ((t - gesture_at) > 32'(cfg.release_timeout_ms) ||
                    motion < cfg.release_motion_level)
                begin
                    phase_q    = PH_WAIT_NEUTRAL;
                    locked     = POSE_UNKNOWN;
                    prior_pose = POSE_UNKNOWN;
                    hold_from  = t;
                    flat_from  = t;
                end
            end
            PH_WAIT_NEUTRAL:
            begin
                if (p == POSE_FLAT)
                begin
                    // zero stamp doubles as "not started"
                    if (flat_from == 32'd0)
                        flat_from = t;
                    if ((t - flat_from) >= 32'(cfg.neutral_hold_ms))
                    begin
                        phase_q    = PH_WAIT_POSE;
                        locked     = POSE_UNKNOWN;
                        prior_pose = p;
                        hold_from  = t;
                        flat_from  = 32'd0;
                    end
                end
                else
                begin
                    flat_from = 32'd0;
                end
            end
            PH_WAIT_POSE:
            begin
                if (p != prior_pose)
                begin
                    locked     = POSE_UNKNOWN;
                    prior_pose = p;
                    hold_from  = t;
                end
                else if (p == POSE_UNKNOWN || p == POSE_FLAT ||
                         motion >= cfg.arm_motion_limit)
                begin
                    hold_from = t;
                end
                else if ((t - hold_from) >= 32'(cfg.pose_hold_ms))
                begin
                    locked  = p;
                    phase_q = PH_ARMED;
                end
            end
            default:
            begin
                if (motion > cfg.trigger_motion_level)
                begin
                    case (locked)
                        POSE_CCW90: g = GEST_LEFT;
                        POSE_CW90:  g = GEST_RIGHT;
                        POSE_CW180: g = GEST_UP;
                        default:    g = GEST_NONE;
                    endcase
                    if (g != GEST_NONE)
                    begin
                        gesture_at = t;
                        flat_from  = 32'd0;
                        phase_q    = PH_WAIT_RELEASE;
                    end
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg        = CFG_RESET;
            phase_q    = PH_WAIT_POSE;
            gesture_at = 32'd0;
            hold_from  = 32'd0;
            flat_from  = 32'd0;
            locked     = POSE_UNKNOWN;
            prior_pose = POSE_UNKNOWN;
            due_outcomes.delete();
            errors     = 0;
            pending   <= 0;
        end
        else
        begin
            if (result_mon.valid && result_mon.ready)
            begin
                if (due_outcomes.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected result word: gesture %0d phase %0d",
                                 result_mon.gesture_code, result_mon.phase_after);
                    errors++;
                end
                else
                begin
                    want = due_outcomes.pop_front();
                    if (result_mon.gesture_code !== want.gesture ||
                        result_mon.phase_after !== want.phase)
                    begin
                        if (errors < 10)
                            $display("result mismatch: gesture exp %0d got %0d, phase exp %0d got %0d",
                                     want.gesture, result_mon.gesture_code,
                                     want.phase, result_mon.phase_after);
                        errors++;
                    end
                end
            end
            if (sample_mon.valid && sample_mon.ready)
            begin
                seen_word.accel_x = sample_mon.accel_x;
                seen_word.accel_y = sample_mon.accel_y;
                seen_word.accel_z = sample_mon.accel_z;
                seen_word.gyro_x  = sample_mon.gyro_x;
                seen_word.gyro_y  = sample_mon.gyro_y;
                seen_word.gyro_z  = sample_mon.gyro_z;
                seen_word.now_ms  = sample_mon.now_ms;
                recognize(seen_word, fired);
                due_outcomes.push_back('{gesture: fired, phase: phase_q});
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[APB_ADDR_W-1:2])
                    REG_TRIGGER_MOTION:  cfg.trigger_motion_level = pwdata[MOTION_W-1:0];
                    REG_RELEASE_MOTION:  cfg.release_motion_level = pwdata[MOTION_W-1:0];
                    REG_RELEASE_TIMEOUT: cfg.release_timeout_ms   = pwdata[15:0];
                    REG_POSE_HOLD:       cfg.pose_hold_ms         = pwdata[15:0];
                    REG_ARM_MOTION:      cfg.arm_motion_limit     = pwdata[MOTION_W-1:0];
                    REG_NEUTRAL_HOLD:    cfg.neutral_hold_ms      = pwdata[15:0];
                    default: ;
                endcase
            end
            pending <= due_outcomes.size();
        end
    end

endmodule

// ===== sim/tb_imu_pose_gesture_recognizer_top.sv =====
// Testbench top: drives samples and register writes into the recognizer and reports the verdict.
module tb_imu_pose_gesture_recognizer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import imupg_pkg::*;

    localparam int CLK_PERIOD      = 8;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_SLACK     = 6;
    localparam int TIMEOUT_NS      = 2_000_000;

    localparam logic [REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int          errors;
    int          pending;
    bit          idle_on      = 1'b1;
    bit          hold_off_req = 1'b0;
    logic [31:0] stamp;
    int          items_sent   = 0;

    int trig_lv = 10000;
    int rel_lv  = 4000;
    int rel_to  = 700;
    int hold_ms = 180;
    int arm_lv  = 5000;
    int neut_ms = 200;

    imupg_in_if  sample_in();
    imupg_out_if result_out();

    imu_pose_gesture_recognizer_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (sample_in),
        .result_out (result_out),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    imupg_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_mon (sample_in),
        .result_mon (result_out),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .errors     (errors),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result sink; a hold-off request blocks it for a counted stretch
    initial
    begin
        result_out.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                result_out.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                result_out.ready <= (!idle_on || $urandom_range(0, 99) >= 7);
            end
        end
    end

    task automatic send_word(input sample_t s);
        if (idle_on && $urandom_range(0, 99) < 7)
        begin
            sample_in.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        sample_in.valid   <= 1'b1;
        sample_in.accel_x <= s.accel_x;
        sample_in.accel_y <= s.accel_y;
        sample_in.accel_z <= s.accel_z;
        sample_in.gyro_x  <= s.gyro_x;
        sample_in.gyro_y  <= s.gyro_y;
        sample_in.gyro_z  <= s.gyro_z;
        sample_in.now_ms  <= s.now_ms;
        @(posedge clk);
        while (sample_in.ready !== 1'b1) @(posedge clk);
        items_sent++;
    endtask

    task automatic drain();
        sample_in.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [31:0] t, input logic [31:0] r,
                                  input logic [31:0] rt, input logic [31:0] h,
                                  input logic [31:0] a, input logic [31:0] n);
        drain();
        repeat (DRAIN_SLACK) @(posedge clk);
        write_reg(REG_TRIGGER_MOTION, t);
        write_reg(REG_RELEASE_MOTION, r);
        write_reg(REG_RELEASE_TIMEOUT, rt);
        write_reg(REG_POSE_HOLD, h);
        write_reg(REG_ARM_MOTION, a);
        write_reg(REG_NEUTRAL_HOLD, n);
        trig_lv = int'(t[16:0]);
        rel_lv  = int'(r[16:0]);
        rel_to  = int'(rt[15:0]);
        hold_ms = int'(h[15:0]);
        arm_lv  = int'(a[16:0]);
        neut_ms = int'(n[15:0]);
    endtask

    task automatic put(input int ax, input int ay, input int az,
                       input int gx, input int gy, input int gz, input logic [31:0] t);
        sample_t s;
        s.accel_x = 16'(ax);
        s.accel_y = 16'(ay);
        s.accel_z = 16'(az);
        s.gyro_x  = 16'(gx);
        s.gyro_y  = 16'(gy);
        s.gyro_z  = 16'(gz);
        s.now_ms  = t;
        send_word(s);
    endtask

    function automatic logic signed [15:0] with_sign(input int m);
        if (m >= 32768)
            return 16'sh8000;
        return ($urandom_range(0, 1) != 0) ? 16'(-m) : 16'(m);
    endfunction

    function automatic int quiet_motion();
        int lim;
        lim = (arm_lv < rel_lv) ? arm_lv : rel_lv;
        if (lim > 98305)
            lim = 98305;
        return (lim > 0) ? int'($urandom_range(0, lim - 1)) : 0;
    endfunction

    function automatic int burst_motion();
        return (trig_lv < 98304) ? int'($urandom_range(trig_lv + 1, 98304)) : 98304;
    endfunction

    function automatic sample_t shape_sample(input pose_t p, input int motion);
        sample_t s;
        int      dom;
        int      a;
        int      b;
        dom = ($urandom_range(0, 9) == 0) ? 32767 : int'($urandom_range(1, 32767));
        s.accel_x = with_sign($urandom_range(0, dom - 1));
        s.accel_y = with_sign($urandom_range(0, dom - 1));
        s.accel_z = with_sign($urandom_range(0, dom - 1));
        case (p)
            POSE_FLAT:  s.accel_z = 16'(dom);
            POSE_CW180: s.accel_z = 16'(-dom);
            POSE_CCW90:
            begin
                if ($urandom_range(0, 1) != 0)
                    s.accel_x = 16'(dom);
                else
                    s.accel_y = 16'(dom);
            end
            default:
            begin
                if ($urandom_range(0, 1) != 0)
                    s.accel_x = 16'(-dom);
                else
                    s.accel_y = 16'(-dom);
            end
        endcase
        a = motion / 3;
        b = (motion - a) / 2;
        s.gyro_x = with_sign(a);
        s.gyro_y = with_sign(b);
        s.gyro_z = with_sign(motion - a - b);
        s.now_ms = stamp;
        return s;
    endfunction

    task automatic tick(input int step);
        stamp = stamp + 32'(step);
    endtask

    // flat settle, pose hold, burst, release, flat hold
    task automatic run_gesture();
        pose_t p;
        int    n;
        int    i;
        int    step;
        case ($urandom_range(0, 2))
            0:       p = POSE_CCW90;
            1:       p = POSE_CW90;
            default: p = POSE_CW180;
        endcase
        n = $urandom_range(1, 3);
        for (i = 0; i < n; i++)
        begin
            tick($urandom_range(0, neut_ms / 2 + 1));
            send_word(shape_sample(POSE_FLAT, quiet_motion()));
        end
        n    = $urandom_range(2, 5);
        step = hold_ms / (n - 1) + 1;
        for (i = 0; i < n; i++)
        begin
            tick(($urandom_range(0, 7) == 0) ? int'($urandom_range(0, step)) : step);
            send_word(shape_sample(p, ($urandom_range(0, 11) == 0) ? burst_motion()
                                                                 : quiet_motion()));
        end
        n = $urandom_range(1, 2);
        for (i = 0; i < n; i++)
        begin
            tick($urandom_range(0, 20));
            send_word(shape_sample(p, burst_motion()));
        end
        if ($urandom_range(0, 1) != 0)
        begin
            tick($urandom_range(0, 20));
            send_word(shape_sample(p, quiet_motion()));
        end
        else
        begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++)
            begin
                tick(rel_to / n + 1);
                send_word(shape_sample(p, burst_motion()));
            end
        end
        n    = $urandom_range(2, 5);
        step = neut_ms / (n - 1) + 1;
        for (i = 0; i < n; i++)
        begin
            tick(($urandom_range(0, 7) == 0) ? int'($urandom_range(0, step)) : step);
            send_word(shape_sample(($urandom_range(0, 9) == 0) ? p : POSE_FLAT,
                                   quiet_motion()));
        end
    endtask

    task automatic noise_burst();
        sample_t s;
        int      n;
        int      i;
        n = $urandom_range(1, 8);
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                stamp = $urandom;
            else
                tick($urandom_range(0, 300));
            s        = 112'({$urandom, $urandom, $urandom, $urandom});
            s.now_ms = stamp;
            send_word(s);
        end
    endtask

    task automatic run_phase(input int budget);
        int start;
        start = items_sent;
        while (items_sent - start < budget)
        begin
            if ($urandom_range(0, 3) == 0)
                noise_burst();
            else
                run_gesture();
        end
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        sample_in.valid   <= 1'b0;
        sample_in.accel_x <= '0;
        sample_in.accel_y <= '0;
        sample_in.accel_z <= '0;
        sample_in.gyro_x  <= '0;
        sample_in.gyro_y  <= '0;
        sample_in.gyro_z  <= '0;
        sample_in.now_ms  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: ties, each gesture, threshold edges, wrap and zero stamp
        put(0, 0, 0, 0, 0, 0, 32'd0);
        put(32767, 0, -32767, 0, 0, 0, 32'd10);
        put(-32768, 0, 32767, 0, 0, 0, 32'd20);
        put(-5, 5, 0, 0, 0, 0, 32'd30);
        put(0, 20000, 100, 0, 0, 0, 32'd100);
        put(0, 20000, 100, 1000, -1000, 500, 32'd200);
        put(0, 20000, 100, 0, 0, 0, 32'd280);
        put(0, 20000, 100, -32768, -32768, -32768, 32'd300);
        put(0, 20000, 100, 32767, 32767, 32767, 32'd900);
        put(0, 20000, 100, 32767, 32767, 32767, 32'd1001);
        put(0, 0, 16000, 0, 0, 0, 32'd1100);
        put(0, 0, 16000, 0, 0, 0, 32'd1201);
        put(-30000, 0, 0, 0, 0, 0, 32'd1300);
        put(-30000, 0, 0, 5000, 0, 0, 32'd1400);
        put(-30000, 0, 0, 4999, 0, 0, 32'd1579);
        put(-30000, 0, 0, 0, 0, 0, 32'd1580);
        put(-30000, 0, 0, 10000, 0, 0, 32'd1590);
        put(-30000, 0, 0, 10001, 0, 0, 32'd1600);
        put(-30000, 0, 0, 4000, 0, 0, 32'd1610);
        put(-30000, 0, 0, 3999, 0, 0, 32'd1620);
        put(0, 0, -20000, 0, 0, 0, 32'd1700);
        put(0, 0, 20000, 0, 0, 0, 32'd1800);
        put(0, 0, 20000, 0, 0, 0, 32'd2000);
        put(0, 0, -20000, 0, 0, 0, 32'd2100);
        put(0, 0, -20000, 0, 0, 0, 32'd2300);
        put(0, 0, -20000, 20000, 0, 0, 32'hFFFF_FFF0);
        put(0, 0, -20000, 0, 0, 0, 32'd0);
        put(0, 0, 20000, 0, 0, 0, 32'd150);
        put(0, 0, 20000, 0, 0, 0, 32'd350);

        stamp = 32'd400;
        apply_settings(10000, 4000, 60, 30, 5000, 40);
        run_phase(60);
        hold_off_req = 1'b1;
        run_phase(60);
        drain();
        run_phase(70);

        idle_on = 1'b0;
        apply_settings($urandom_range(2000, 40000), $urandom_range(500, 20000),
                       $urandom_range(0, 300), $urandom_range(0, 100),
                       $urandom_range(1000, 30000), $urandom_range(0, 100));
        run_phase(190);
        idle_on = 1'b1;

        apply_settings(0, 0, 0, 0, 0, 0);
        run_phase(150);

        apply_settings(0, 98304, 65535, 65535, 98304, 65535);
        run_phase(190);

        apply_settings(98303, 0, 0, 0, 1, 0);
        run_phase(150);

        // all ones: values beyond range are masked to register width
        apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_A, $urandom);
        write_reg(REG_SPARE_B, $urandom);
        run_phase(150);

        stamp = 32'hFFFF_F000;
        apply_settings($urandom_range(0, 98304), $urandom_range(0, 98304),
                       $urandom_range(0, 65535), $urandom_range(0, 65535),
                       $urandom_range(0, 98304), $urandom_range(0, 65535));
        run_phase(250);

        apply_settings($urandom_range(0, 98304), $urandom_range(0, 98304),
                       $urandom_range(0, 2000), $urandom_range(0, 2000),
                       $urandom_range(0, 98304), $urandom_range(0, 2000));
        run_phase(250);

        drain();
        repeat (DRAIN_SLACK) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
